### rtl/qicd_pkg.sv
// Shared constants and types for the quantized int8 cosine distance core.
package qicd_pkg;

  localparam int MAX_DIM = 4096;
  localparam int CNT_W   = $clog2(MAX_DIM + 1);
  localparam int DOT_W   = CNT_W + 15;
  localparam int ELEM_W  = 8;
  localparam int EPROD_W = 2 * ELEM_W;
  localparam int SCALE_W = 32;
  localparam int SUM_W   = 20;
  localparam int OP_W    = SCALE_W + 1;
  localparam int PROD_W  = 2 * OP_W;
  localparam int ACC_W   = PROD_W + SCALE_W;
  localparam int DIST_W  = 64;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] CFG_QUERY_SCALE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_QUERY_BIAS  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_QUERY_SUM   = 2'd2;

  localparam logic signed [SCALE_W-1:0] QUERY_SCALE_RST = 32'sd65536;

  typedef struct packed {
    logic signed [SCALE_W-1:0] rs;
    logic signed [SCALE_W-1:0] rb;
    logic signed [SUM_W-1:0]   rsum;
    logic signed [SCALE_W-1:0] qs;
    logic signed [SCALE_W-1:0] qb;
    logic signed [SUM_W-1:0]   qsum;
    logic signed [DOT_W-1:0]   dot;
    logic [CNT_W-1:0]          count;
  } qicd_operands_t;

endpackage

### rtl/qicd_combine.sv
// Sequenced final combination of one record on a shared multiplier, with saturation.
module qicd_combine (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  input  qicd_pkg::qicd_operands_t        ops,
  output logic                            done,
  output logic signed [qicd_pkg::DIST_W-1:0] result
);
  import qicd_pkg::*;

  localparam logic [1:0] C_IDLE = 2'd0;
  localparam logic [1:0] C_MUL  = 2'd1;
  localparam logic [1:0] C_ACC  = 2'd2;
  localparam logic [1:0] C_FIN  = 2'd3;

  localparam logic [1:0] SUB_AB = 2'd0;
  localparam logic [1:0] SUB_LO = 2'd1;
  localparam logic [1:0] SUB_HI = 2'd2;

  localparam logic [1:0] TERM_DOT  = 2'd0;
  localparam logic [1:0] TERM_QSUM = 2'd1;
  localparam logic [1:0] TERM_RSUM = 2'd2;
  localparam logic [1:0] TERM_CNT  = 2'd3;

  logic [1:0]                state_r;
  logic [1:0]                sub_r;
  logic [1:0]                term_r;
  logic                      done_r;
  qicd_operands_t            ops_r;
  logic signed [PROD_W-1:0]  prod_r;
  logic [2*SCALE_W-1:0]      p_r;
  logic signed [ACC_W-1:0]   acc_r;
  logic signed [DIST_W-1:0]  result_r;

  logic signed [SCALE_W-1:0] term_a;
  logic signed [SCALE_W-1:0] term_b;
  logic signed [OP_W-1:0]    term_c;
  logic signed [OP_W-1:0]    mul_x;
  logic signed [OP_W-1:0]    mul_y;
  logic signed [PROD_W-1:0]  mul_out;
  logic signed [ACC_W-1:0]   neg_acc;
  logic [ACC_W-DIST_W:0]     neg_upper;
  logic signed [DIST_W-1:0]  sat_val;

  always_comb begin
    unique case (term_r)
      TERM_DOT: begin
        term_a = ops_r.rs;
        term_b = ops_r.qs;
        term_c = {{(OP_W-DOT_W){ops_r.dot[DOT_W-1]}}, ops_r.dot};
      end
      TERM_QSUM: begin
        term_a = ops_r.rb;
        term_b = ops_r.qs;
        term_c = {{(OP_W-SUM_W){ops_r.qsum[SUM_W-1]}}, ops_r.qsum};
      end
      TERM_RSUM: begin
        term_a = ops_r.qb;
        term_b = ops_r.rs;
        term_c = {{(OP_W-SUM_W){ops_r.rsum[SUM_W-1]}}, ops_r.rsum};
      end
      default: begin
        term_a = ops_r.qb;
        term_b = ops_r.rb;
        term_c = {{(OP_W-CNT_W){1'b0}}, ops_r.count};
      end
    endcase
  end

  always_comb begin
    unique case (sub_r)
      SUB_AB: begin
        mul_x = {term_a[SCALE_W-1], term_a};
        mul_y = {term_b[SCALE_W-1], term_b};
      end
      SUB_LO: begin
        mul_x = {1'b0, p_r[SCALE_W-1:0]};
        mul_y = term_c;
      end
      default: begin
        mul_x = {p_r[2*SCALE_W-1], p_r[2*SCALE_W-1:SCALE_W]};
        mul_y = term_c;
      end
    endcase
  end

  assign mul_out   = mul_x * mul_y;
  assign neg_acc   = -acc_r;
  assign neg_upper = neg_acc[ACC_W-1:DIST_W-1];

  always_comb begin
    if ((&neg_upper) || (~|neg_upper)) begin
      sat_val = neg_acc[DIST_W-1:0];
    end else if (neg_acc[ACC_W-1]) begin
      sat_val = {1'b1, {(DIST_W-1){1'b0}}};
    end else begin
      sat_val = {1'b0, {(DIST_W-1){1'b1}}};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= C_IDLE;
      sub_r   <= SUB_AB;
      term_r  <= TERM_DOT;
      done_r  <= 1'b0;
    end else begin
      done_r <= 1'b0;
      unique case (state_r)
        C_IDLE: begin
          if (start) begin
            sub_r   <= SUB_AB;
            term_r  <= TERM_DOT;
            state_r <= C_MUL;
          end
        end
        C_MUL: begin
          state_r <= C_ACC;
        end
        C_ACC: begin
          if (sub_r == SUB_HI) begin
            sub_r <= SUB_AB;
            if (term_r == TERM_CNT) begin
              state_r <= C_FIN;
            end else begin
              term_r  <= term_r + 2'd1;
              state_r <= C_MUL;
            end
          end else begin
            sub_r   <= sub_r + 2'd1;
            state_r <= C_MUL;
          end
        end
        default: begin
          done_r  <= 1'b1;
          state_r <= C_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == C_IDLE && start) begin
      ops_r <= ops;
      acc_r <= '0;
    end
    if (state_r == C_MUL) begin
      prod_r <= mul_out;
    end
    if (state_r == C_ACC) begin
      case (sub_r)
        SUB_AB:  p_r   <= prod_r[2*SCALE_W-1:0];
        SUB_LO:  acc_r <= acc_r + {{(ACC_W-PROD_W){prod_r[PROD_W-1]}}, prod_r};
        default: acc_r <= acc_r + {prod_r, {(ACC_W-PROD_W){1'b0}}};
      endcase
    end
    if (state_r == C_FIN) begin
      result_r <= sat_val;
    end
  end

  assign done   = done_r;
  assign result = result_r;

endmodule

### rtl/quantized_int8_cosine_distance_core.sv
// Top level of the quantized int8 inner-product distance core.
//
//  Channel  | Direction | Handshake           | Payload
//  in_      | input     | in_valid/in_ready   | element pair, last, record scale/bias/sum
//  out_     | output    | out_valid/out_ready | distance
//  cfg_     | input     | cfg_we              | cfg_index, cfg_wdata
//
// Elements of a record are taken one per cycle while the core is streaming.
// The element carrying last is followed by a busy phase: 12 passes of the
// shared 33 by 33 multiplier, each a multiply and an accumulate state, plus
// start, saturation, the done pulse and output load. A result still waiting
// at the output delays the next load, and with it the input, until taken.
// Reset is synchronous and active low and returns the query registers to
// their defaults and clears the running dot product and element count.
module quantized_int8_cosine_distance_core (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  logic                                    in_valid,
  output logic                                    in_ready,
  input  logic signed [qicd_pkg::ELEM_W-1:0]      in_record_element,
  input  logic signed [qicd_pkg::ELEM_W-1:0]      in_query_element,
  input  logic                                    in_last,
  input  logic signed [qicd_pkg::SCALE_W-1:0]     in_record_scale,
  input  logic signed [qicd_pkg::SCALE_W-1:0]     in_record_bias,
  input  logic signed [qicd_pkg::SUM_W-1:0]       in_record_sum,
  output logic                                    out_valid,
  input  logic                                    out_ready,
  output logic signed [qicd_pkg::DIST_W-1:0]      out_distance,
  input  logic                                    cfg_we,
  input  logic [qicd_pkg::CFG_IDX_W-1:0]          cfg_index,
  input  logic [qicd_pkg::CFG_DATA_W-1:0]         cfg_wdata
);
  import qicd_pkg::*;

  localparam logic [1:0] S_STREAM = 2'd0;
  localparam logic [1:0] S_START  = 2'd1;
  localparam logic [1:0] S_CALC   = 2'd2;
  localparam logic [1:0] S_OUT    = 2'd3;

  logic [1:0]                 state_r;
  logic signed [SCALE_W-1:0]  qs_r;
  logic signed [SCALE_W-1:0]  qb_r;
  logic signed [SUM_W-1:0]    qsum_r;
  logic signed [SCALE_W-1:0]  rs_r;
  logic signed [SCALE_W-1:0]  rb_r;
  logic signed [SUM_W-1:0]    rsum_r;
  logic signed [DOT_W-1:0]    dot_r;
  logic [CNT_W-1:0]           count_r;
  logic                       out_valid_r;
  logic signed [DIST_W-1:0]   out_distance_r;

  logic                       in_xfer;
  logic                       room;
  logic                       out_load;
  logic signed [EPROD_W-1:0]  elem_prod;
  logic                       comb_done;
  logic signed [DIST_W-1:0]   comb_result;
  qicd_operands_t             ops;

  assign in_ready  = (state_r == S_STREAM);
  assign in_xfer   = in_valid && in_ready;
  assign room      = (count_r < CNT_W'(MAX_DIM));
  assign out_load  = (state_r == S_OUT) && (!out_valid_r || out_ready);
  assign elem_prod = in_record_element * in_query_element;

  assign ops.rs    = rs_r;
  assign ops.rb    = rb_r;
  assign ops.rsum  = rsum_r;
  assign ops.qs    = qs_r;
  assign ops.qb    = qb_r;
  assign ops.qsum  = qsum_r;
  assign ops.dot   = dot_r;
  assign ops.count = count_r;

  qicd_combine u_combine (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (state_r == S_START),
    .ops    (ops),
    .done   (comb_done),
    .result (comb_result)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      qs_r   <= QUERY_SCALE_RST;
      qb_r   <= '0;
      qsum_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_QUERY_SCALE: qs_r   <= cfg_wdata[SCALE_W-1:0];
        CFG_QUERY_BIAS:  qb_r   <= cfg_wdata[SCALE_W-1:0];
        CFG_QUERY_SUM:   qsum_r <= cfg_wdata[SUM_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_STREAM;
      dot_r       <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_STREAM: begin
          if (in_xfer) begin
            if (room) begin
              dot_r   <= dot_r + {{(DOT_W-EPROD_W){elem_prod[EPROD_W-1]}}, elem_prod};
              count_r <= count_r + CNT_W'(1);
            end
            if (in_last) begin
              state_r <= S_START;
            end
          end
        end
        S_START: begin
          state_r <= S_CALC;
        end
        S_CALC: begin
          if (comb_done) begin
            state_r <= S_OUT;
          end
        end
        default: begin
          if (out_load) begin
            dot_r       <= '0;
            count_r     <= '0;
            state_r     <= S_STREAM;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer && in_last) begin
      rs_r   <= in_record_scale;
      rb_r   <= in_record_bias;
      rsum_r <= in_record_sum;
    end
    if (out_load) begin
      out_distance_r <= comb_result;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_distance = out_distance_r;

endmodule

### tb/tb.sv
// Self-checking testbench for the quantized int8 inner-product distance core.
`timescale 1ns / 100ps

module tb;

  import qicd_pkg::*;

  localparam int SETTLE_CYCLES = 40;
  localparam int STALL_LIMIT   = 2000;
  localparam int RANDOM_ITEMS  = 1700;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_IDX = 2'd3;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  logic                       in_valid          = 1'b0;
  logic                       in_ready;
  logic signed [ELEM_W-1:0]   in_record_element = '0;
  logic signed [ELEM_W-1:0]   in_query_element  = '0;
  logic                       in_last           = 1'b0;
  logic signed [SCALE_W-1:0]  in_record_scale   = '0;
  logic signed [SCALE_W-1:0]  in_record_bias    = '0;
  logic signed [SUM_W-1:0]    in_record_sum     = '0;
  logic                       out_valid;
  logic                       out_ready         = 1'b0;
  logic signed [DIST_W-1:0]   out_distance;
  logic                       cfg_we            = 1'b0;
  logic [CFG_IDX_W-1:0]       cfg_index         = '0;
  logic [CFG_DATA_W-1:0]      cfg_wdata         = '0;

  // Copy of the query registers and the running record state.
  logic signed [SCALE_W-1:0]  q_scale = QUERY_SCALE_RST;
  logic signed [SCALE_W-1:0]  q_bias  = '0;
  logic signed [SUM_W-1:0]    q_sum   = '0;
  logic signed [DOT_W-1:0]    dot_sum = '0;
  int                         elem_count = 0;

  logic signed [DIST_W-1:0]   expected_distance[$];
  logic signed [DIST_W-1:0]   want_distance;

  int send_idle_pct = 33;
  int recv_idle_pct = 83;
  int errors        = 0;
  int items_sent    = 0;
  int quiet_cycles  = 0;

  quantized_int8_cosine_distance_core i_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_record_element (in_record_element),
    .in_query_element  (in_query_element),
    .in_last           (in_last),
    .in_record_scale   (in_record_scale),
    .in_record_bias    (in_record_bias),
    .in_record_sum     (in_record_sum),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_distance      (out_distance),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Transfers are judged at the falling edge, where every input and output is settled.
  always @(negedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (expected_distance.size() == 0) begin
        $error("distance: expected none, actual %0d", out_distance);
        errors++;
      end else begin
        want_distance = expected_distance.pop_front();
        if (out_distance !== want_distance) begin
          $error("distance: expected %0d, actual %0d", want_distance, out_distance);
          errors++;
        end
      end
    end
  end

  always @(negedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("** quantized_int8_cosine_distance_core: FAILED **");
        $finish;
      end
    end
  end

  function automatic logic signed [DIST_W-1:0] dequant_distance(
    input logic signed [SCALE_W-1:0] rs,
    input logic signed [SCALE_W-1:0] rb,
    input logic signed [SUM_W-1:0]   rsum
  );
    logic signed [63:0]  pair;
    logic signed [127:0] term;
    logic signed [127:0] exact;
    pair  = rs * q_scale;
    term  = pair;
    exact = term * dot_sum;
    pair  = rb * q_scale;
    term  = pair;
    exact = exact + term * q_sum;
    pair  = q_bias * rs;
    term  = pair;
    exact = exact + term * rsum;
    pair  = q_bias * rb;
    term  = pair;
    exact = exact + term * elem_count;
    exact = -exact;
    if (exact[127:63] == '0 || exact[127:63] == '1) begin
      return exact[63:0];
    end
    return exact[127] ? {1'b1, 63'b0} : {1'b0, {63{1'b1}}};
  endfunction

  function automatic void accept_element(
    input logic signed [ELEM_W-1:0]  re,
    input logic signed [ELEM_W-1:0]  qe,
    input logic                      last,
    input logic signed [SCALE_W-1:0] rs,
    input logic signed [SCALE_W-1:0] rb,
    input logic signed [SUM_W-1:0]   rsum
  );
    if (elem_count < MAX_DIM) begin
      dot_sum = dot_sum + re * qe;
      elem_count++;
    end
    if (last) begin
      expected_distance.push_back(dequant_distance(rs, rb, rsum));
      dot_sum    = '0;
      elem_count = 0;
    end
  endfunction

  function automatic logic signed [SCALE_W-1:0] rand_q16();
    case ($urandom_range(7))
      0: return 32'sh8000_0000;
      1: return 32'sh7FFF_FFFF;
      2: return '0;
      3: return $urandom;
      default: return $signed($urandom) >>> $urandom_range(31);
    endcase
  endfunction

  function automatic logic signed [SUM_W-1:0] rand_sum();
    case ($urandom_range(7))
      0: return 20'sh80000;
      1: return 20'sh7FFFF;
      2: return '0;
      3: return 20'($urandom);
      default: return $signed(20'($urandom)) >>> $urandom_range(19);
    endcase
  endfunction

  function automatic logic signed [ELEM_W-1:0] rand_elem();
    case ($urandom_range(9))
      0: return 8'sh80;
      1: return 8'sh7F;
      default: return 8'($urandom);
    endcase
  endfunction

  task automatic send_element(
    input logic signed [ELEM_W-1:0]  re,
    input logic signed [ELEM_W-1:0]  qe,
    input logic                      last,
    input logic signed [SCALE_W-1:0] rs,
    input logic signed [SCALE_W-1:0] rb,
    input logic signed [SUM_W-1:0]   rsum
  );
    bit took;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid          <= 1'b1;
    in_record_element <= re;
    in_query_element  <= qe;
    in_last           <= last;
    in_record_scale   <= rs;
    in_record_bias    <= rb;
    in_record_sum     <= rsum;
    do begin
      @(negedge clk);
      took = in_ready;
      @(posedge clk);
    end while (!took);
    accept_element(re, qe, last, rs, rb, rsum);
    items_sent++;
  endtask

  // Fields that only matter on the last transfer carry random values elsewhere.
  task automatic send_record(
    input int                        len,
    input bit                        use_fix,
    input logic signed [ELEM_W-1:0]  re_fix,
    input logic signed [ELEM_W-1:0]  qe_fix,
    input logic signed [SCALE_W-1:0] rs,
    input logic signed [SCALE_W-1:0] rb,
    input logic signed [SUM_W-1:0]   rsum
  );
    logic signed [ELEM_W-1:0] re;
    logic signed [ELEM_W-1:0] qe;
    for (int k = 0; k < len; k++) begin
      re = use_fix ? re_fix : rand_elem();
      qe = use_fix ? qe_fix : rand_elem();
      if (k == len - 1) begin
        send_element(re, qe, 1'b1, rs, rb, rsum);
      end else begin
        send_element(re, qe, 1'b0, $urandom, $urandom, 20'($urandom));
      end
    end
  endtask

  task automatic wait_results_done();
    in_valid <= 1'b0;
    while (expected_distance.size() != 0) @(posedge clk);
  endtask

  task automatic settle();
    wait_results_done();
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    case (idx)
      CFG_QUERY_SCALE: q_scale = data;
      CFG_QUERY_BIAS:  q_bias  = data;
      CFG_QUERY_SUM:   q_sum   = data[SUM_W-1:0];
      default: ;
    endcase
  endtask

  task automatic write_query(
    input logic signed [SCALE_W-1:0] qs,
    input logic signed [SCALE_W-1:0] qb,
    input logic signed [SUM_W-1:0]   qsum
  );
    write_reg(CFG_QUERY_SCALE, qs);
    write_reg(CFG_QUERY_BIAS, qb);
    write_reg(CFG_QUERY_SUM, {{(CFG_DATA_W-SUM_W){qsum[SUM_W-1]}}, qsum});
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic test_reset_defaults();
    send_record(1, 1'b1, 8'sh7F, 8'sh7F, 32'sd65536, 32'sd0, 20'sd0);
    send_record(3, 1'b1, 8'sh80, 8'sh80, 32'sd65536, 32'sd65536, 20'sh7FFFF);
    send_element(8'sh80, 8'sh7F, 1'b0, $urandom, $urandom, 20'($urandom));
    send_element(8'sh7F, 8'sh80, 1'b0, $urandom, $urandom, 20'($urandom));
    send_element(8'sh00, 8'sh01, 1'b1, 32'sh8000_0000, 32'sh7FFF_FFFF, 20'sh80000);
    settle();
  endtask

  // Both signs of saturation and the extreme register values.
  task automatic test_extremes();
    write_query(32'sh8000_0000, 32'sh7FFF_FFFF, 20'sh80000);
    send_record(1, 1'b1, 8'sh80, 8'sh80, 32'sh8000_0000, 32'sh7FFF_FFFF, 20'sh80000);
    send_record(1, 1'b1, 8'sh7F, 8'sh80, 32'sh8000_0000, 32'sh8000_0000, 20'sh7FFFF);
    send_record(2, 1'b1, 8'sh7F, 8'sh7F, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 20'sh7FFFF);
    send_record(1, 1'b1, 8'sh00, 8'sh00, 32'sd0, 32'sd0, 20'sd0);
    settle();
    write_query(32'sh7FFF_FFFF, 32'sh8000_0000, 20'sh7FFFF);
    send_record(1, 1'b1, 8'sh80, 8'sh7F, 32'sh7FFF_FFFF, 32'sh8000_0000, 20'sh80000);
    send_record(2, 1'b1, 8'sh01, 8'shFF, 32'sd1, 32'shFFFF_FFFF, 20'sh00001);
    settle();
  endtask

  task automatic test_unknown_register();
    write_query(32'sd65536, 32'sd32768, 20'sd1000);
    write_reg(CFG_UNUSED_IDX, '1);
    cfg_we <= 1'b0;
    @(posedge clk);
    send_record(4, 1'b0, '0, '0, 32'sd131072, 32'shFFFF_0000, 20'sd200);
    settle();
  endtask

  // One record that fills the element limit and ends with a last mark on a dropped element, then a one-element record.
  task automatic test_too_many_elements();
    write_query(32'sd65536, 32'sd65536, 20'sd5);
    send_record(MAX_DIM + 1, 1'b1, 8'sh80, 8'sh80, 32'sd65536, 32'shFFFF_0000, 20'sh80000);
    send_record(1, 1'b1, 8'sh7F, 8'sh7F, 32'sd65536, 32'sd65536, 20'sd1);
    settle();
  endtask

  task automatic test_random();
    int phase_items;
    int len;
    int pick;
    int phase_quota;
    phase_quota = RANDOM_ITEMS / 6;
    for (int ph = 0; ph < 6; ph++) begin
      case (ph / 2)
        0: begin send_idle_pct = 33; recv_idle_pct = 83; end
        1: begin send_idle_pct = 83; recv_idle_pct = 33; end
        default: begin send_idle_pct = 0; recv_idle_pct = 0; end
      endcase
      if (ph == 1) begin
        write_query(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 20'sh7FFFF);
      end else if (ph == 4) begin
        write_query(32'sh8000_0000, 32'sh8000_0000, 20'sh80000);
      end else begin
        write_query(rand_q16(), rand_q16(), rand_sum());
      end
      phase_items = 0;
      while (phase_items < phase_quota) begin
        pick = $urandom_range(99);
        if (pick < 60) len = $urandom_range(8, 1);
        else if (pick < 95) len = $urandom_range(40, 9);
        else len = $urandom_range(200, 41);
        send_record(len, 1'b0, '0, '0, rand_q16(), rand_q16(), rand_sum());
        phase_items += len;
        if ($urandom_range(19) == 0) wait_results_done();
      end
      settle();
    end
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_defaults();
    test_extremes();
    test_unknown_register();
    test_too_many_elements();
    test_random();
    settle();
    if (errors == 0 && expected_distance.size() == 0) begin
      $display("** quantized_int8_cosine_distance_core: PASSED **");
    end else begin
      $display("** quantized_int8_cosine_distance_core: FAILED **");
    end
    $finish;
  end

endmodule
